// ===== src/fdbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fdbe_pkg;

    localparam int SAMPLE_W = 32;
    localparam int VALUE_W  = 64;

    // one diagonal of the difference table moving down the cell chain
    typedef struct packed {
        logic               valid;  // a transaction occupies this slot
        logic               last;   // final sample of the sequence
        logic               live;   // diag still carries a difference to push down
        logic [VALUE_W-1:0] diag;   // value entering the next level
        logic [VALUE_W-1:0] acc;    // alternating sum collected by the last sample
    } token_t;

endpackage

`default_nettype wire

// ===== src/fdbe_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdbe_cell
    import fdbe_pkg::*;
#(
    parameter int LEVEL = 0
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire token_t tok_in,
    output token_t      tok_out
);

    localparam bit ODD = (LEVEL % 2) == 1;

    logic               active_reg;
    logic [VALUE_W-1:0] trail_reg;
    logic [VALUE_W-1:0] first_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic [VALUE_W-1:0] contrib;
    logic               opening;

    // level opens when a live diagonal reaches an unused cell
    assign opening = tok_in.live && !active_reg;

    // first element of this level, taken from the token when it opens the level now
    always_comb
    begin
        if (opening)
        begin
            contrib = tok_in.diag;
        end
        else if (active_reg)
        begin
            contrib = first_reg;
        end
        else
        begin
            contrib = '0;
        end
    end

    // next token handed to the neighbor
    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.last  = tok_in.last;
        tok_next.live  = tok_in.live && active_reg;
        tok_next.diag  = tok_in.diag - trail_reg;
        if (tok_in.last)
        begin
            tok_next.acc = ODD ? (tok_in.acc - contrib) : (tok_in.acc + contrib);
        end
        else
        begin
            tok_next.acc = tok_in.acc;
        end
    end

    // level state, set when the level opens, cleared by reset or by the last sample of a sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (advance && tok_in.valid)
        begin
            if (tok_in.last)
            begin
                active_reg <= 1'b0;
            end
            else if (opening)
            begin
                active_reg <= 1'b1;
            end
        end
    end

    // trailing and first values of the level
    always_ff @(posedge clk)
    begin
        if (advance && tok_in.valid && tok_in.live)
        begin
            trail_reg <= tok_in.diag;
            if (!active_reg)
            begin
                first_reg <= tok_in.diag;
            end
        end
    end

    // token stage toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== src/finite_difference_back_extrapolator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// backward extrapolation by finite differences
// s_axis: one signed 32-bit sample per transaction in s_tdata, s_tlast marks
//   the final sample of a sequence
// m_axis: one result per sequence, sent for the sample with s_tlast set;
//   m_tdata holds the extrapolated value before the first sample and the
//   running total since reset, m_tuser flags a sequence longer than
//   MAX_LEVELS samples (result then inexact)
// a chain of MAX_LEVELS cells holds one difference level each; every sample
//   enters cell 0 and moves one cell per cycle while the chain advances, so a
//   new sample is accepted every cycle unless a waiting result holds the chain
// the last sample passes each cell's token stage, then the result stage
// reset clears all levels, the sequence state and the running total
// while a result waits with m_tready low the whole chain holds and s_tready
//   drops; it rises again in the cycle the result is taken
module finite_difference_back_extrapolator_unit
    import fdbe_pkg::*;
#(
    parameter int MAX_LEVELS = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    input  wire logic                s_tlast,   // is_last
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [2*VALUE_W-1:0]     m_tdata,   // [63:0] previous_value, [127:64] running_total
    output logic [0:0]               m_tuser    // [0] too_long
);

    token_t             chain [MAX_LEVELS];
    token_t             tok_head;
    token_t             tok_tail;
    logic               advance;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] prev_value_reg;
    logic [VALUE_W-1:0] total_sum_reg;
    logic               too_long_reg;
    logic               overflow_seen_reg;

    // chain moves whenever the output slot is free or being emptied
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    // incoming transaction as a token, sample sign extended
    always_comb
    begin
        tok_head.valid = s_tvalid;
        tok_head.last  = s_tlast;
        tok_head.live  = 1'b1;
        tok_head.diag  = {{(VALUE_W-SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};
        tok_head.acc   = '0;
    end

    // row of level cells
    for (genvar k = 0; k < MAX_LEVELS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            fdbe_cell #(
                .LEVEL (k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .tok_in  (tok_head),
                .tok_out (chain[k])
            );
        end
        else
        begin : g_rest
            fdbe_cell #(
                .LEVEL (k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .tok_in  (chain[k-1]),
                .tok_out (chain[k])
            );
        end
    end

    assign tok_tail = chain[MAX_LEVELS-1];

    // result stage: a token still live past the last cell means overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            total_sum_reg     <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else
        begin
            if (advance && tok_tail.valid && tok_tail.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && tok_tail.valid)
            begin
                if (tok_tail.last)
                begin
                    total_sum_reg     <= total_sum_reg + tok_tail.acc;
                    overflow_seen_reg <= 1'b0;
                end
                else
                begin
                    overflow_seen_reg <= overflow_seen_reg | tok_tail.live;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && tok_tail.valid && tok_tail.last)
        begin
            prev_value_reg <= tok_tail.acc;
            too_long_reg   <= overflow_seen_reg | tok_tail.live;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {total_sum_reg, prev_value_reg};
    assign m_tuser[0] = too_long_reg;

endmodule

`default_nettype wire
